/* hw/rtl/sfd_pkg.sv */
`timescale 1ns / 1ps

package sfd_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int LEN_W        = 9;
   localparam int ACTION_W     = 2;
   localparam int BYTE_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int MODE_W       = 2;
   localparam int COUNT_W      = 32;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [BYTE_W-1:0] CODE_END     = 8'hC0;
   localparam logic [BYTE_W-1:0] CODE_ESC     = 8'hDB;
   localparam logic [BYTE_W-1:0] CODE_ESC_END = 8'hDC;
   localparam logic [BYTE_W-1:0] CODE_ESC_ESC = 8'hDD;

   localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IN_FRAME = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ESCAPED  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESYNC   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_NEED_MORE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_READY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR     = 2'd2;

   localparam logic [ACTION_W-1:0] ACT_FEED    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_CAPACITY = 3'd0;
   localparam logic [LEN_W-1:0]      CAPACITY_RESET     = LEN_W'(256);

endpackage

/* hw/rtl/sfd_if.sv */
`timescale 1ns / 1ps

interface sfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfd_pkg::ACTION_W-1:0]  action;
   logic [sfd_pkg::BYTE_W-1:0]    data_byte;
   logic [sfd_pkg::BYTE_W-1:0]    read_index;

   modport source(output valid, action, data_byte, read_index, input ready);
   modport sink(input valid, action, data_byte, read_index, output ready);
endinterface

interface sfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfd_pkg::STATUS_W-1:0]  status;
   logic [sfd_pkg::LEN_W-1:0]     frame_length;
   logic [sfd_pkg::BYTE_W-1:0]    read_data;
   logic [sfd_pkg::COUNT_W-1:0]   frames_ok_count;
   logic [sfd_pkg::COUNT_W-1:0]   overflow_count;
   logic [sfd_pkg::COUNT_W-1:0]   bad_escape_count;
   logic [sfd_pkg::COUNT_W-1:0]   dropped_count;

   modport source(output valid, status, frame_length, read_data, frames_ok_count,
                  overflow_count, bad_escape_count, dropped_count, input ready);
   modport sink(input valid, status, frame_length, read_data, frames_ok_count,
                overflow_count, bad_escape_count, dropped_count, output ready);
endinterface

/* hw/rtl/sfd_csr.sv */
`timescale 1ns / 1ps

module sfd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sfd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [sfd_pkg::LEN_W-1:0]       capacity
);

   logic [sfd_pkg::LEN_W-1:0] capacity_ff;
   logic [sfd_pkg::LEN_W-1:0] capacity_in;
   logic                      write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == sfd_pkg::REG_FRAME_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (write_hit) begin
         capacity_in = csr_pwdata[sfd_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= sfd_pkg::CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == sfd_pkg::REG_FRAME_CAPACITY) begin
         csr_prdata = sfd_pkg::CSR_DATA_W'(capacity_ff);
      end
   end

   assign capacity = capacity_ff;

endmodule

/* hw/rtl/slip_frame_decoder.sv */
`timescale 1ns / 1ps

// response: the response to each request transaction is registered
// throughput: one transaction per cycle while the response side is not stalled, set by the
// frame buffer taking one write or one read and the state update in one step
// reset: synchronous, clears decoder mode, frame length and the four totals;
// capacity returns to 256, buffer contents are left as they are
module slip_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   sfd_req_if.sink                         req_chan,
   sfd_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sfd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   logic [sfd_pkg::LEN_W-1:0]    capacity;
   logic [sfd_pkg::LEN_W-1:0]    cap_eff;

   logic [sfd_pkg::MODE_W-1:0]   mode_ff,  mode_in;
   logic [sfd_pkg::LEN_W-1:0]    len_ff,   len_in;
   logic [sfd_pkg::COUNT_W-1:0]  ok_ff,    ok_in;
   logic [sfd_pkg::COUNT_W-1:0]  ovf_ff,   ovf_in;
   logic [sfd_pkg::COUNT_W-1:0]  bad_ff,   bad_in;
   logic [sfd_pkg::COUNT_W-1:0]  drop_ff,  drop_in;

   logic                         out_valid_ff, out_valid_in;
   logic [sfd_pkg::STATUS_W-1:0] status_ff,    status_in;
   logic                         rd_ok_ff,     rd_ok_in;

   logic [sfd_pkg::BYTE_W-1:0]   mem [sfd_pkg::BUFFER_DEPTH];
   logic [sfd_pkg::BYTE_W-1:0]   mem_q_ff;

   logic                         accept;
   logic                         store;
   logic [sfd_pkg::BYTE_W-1:0]   store_val;
   logic [sfd_pkg::LEN_W-1:0]    base;
   logic                         wr_en;
   logic [sfd_pkg::ADDR_W-1:0]   wr_addr;
   logic                         rd_en;

   sfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   assign cap_eff = (capacity > sfd_pkg::LEN_W'(sfd_pkg::BUFFER_DEPTH))
                    ? sfd_pkg::LEN_W'(sfd_pkg::BUFFER_DEPTH) : capacity;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      ok_in     = ok_ff;
      ovf_in    = ovf_ff;
      bad_in    = bad_ff;
      drop_in   = drop_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      store     = 1'b0;
      store_val = req_chan.data_byte;
      base      = len_ff;
      wr_en     = 1'b0;
      wr_addr   = len_ff[sfd_pkg::ADDR_W-1:0];
      rd_en     = 1'b0;
      if (accept) begin
         status_in = sfd_pkg::ST_NEED_MORE;
         rd_ok_in  = 1'b0;
         unique case (req_chan.action)
            sfd_pkg::ACT_FEED: begin
               if (mode_ff == sfd_pkg::MODE_IDLE) begin
                  base = '0;
               end
               len_in = base;
               unique case (mode_ff)
                  sfd_pkg::MODE_IDLE: begin
                     if (req_chan.data_byte == sfd_pkg::CODE_END) begin
                        mode_in = sfd_pkg::MODE_IDLE;
                     end else if (req_chan.data_byte == sfd_pkg::CODE_ESC) begin
                        mode_in = sfd_pkg::MODE_ESCAPED;
                     end else begin
                        mode_in = sfd_pkg::MODE_IN_FRAME;
                        store   = 1'b1;
                     end
                  end
                  sfd_pkg::MODE_IN_FRAME: begin
                     if (req_chan.data_byte == sfd_pkg::CODE_END) begin
                        mode_in = sfd_pkg::MODE_IDLE;
                        if (base != '0) begin
                           ok_in     = ok_ff + 1'b1;
                           status_in = sfd_pkg::ST_READY;
                        end
                     end else if (req_chan.data_byte == sfd_pkg::CODE_ESC) begin
                        mode_in = sfd_pkg::MODE_ESCAPED;
                     end else begin
                        store = 1'b1;
                     end
                  end
                  sfd_pkg::MODE_ESCAPED: begin
                     if (req_chan.data_byte == sfd_pkg::CODE_ESC_END) begin
                        mode_in   = sfd_pkg::MODE_IN_FRAME;
                        store     = 1'b1;
                        store_val = sfd_pkg::CODE_END;
                     end else if (req_chan.data_byte == sfd_pkg::CODE_ESC_ESC) begin
                        mode_in   = sfd_pkg::MODE_IN_FRAME;
                        store     = 1'b1;
                        store_val = sfd_pkg::CODE_ESC;
                     end else begin
                        bad_in    = bad_ff + 1'b1;
                        drop_in   = drop_ff + 1'b1;
                        len_in    = '0;
                        status_in = sfd_pkg::ST_ERROR;
                        mode_in   = (req_chan.data_byte == sfd_pkg::CODE_END)
                                    ? sfd_pkg::MODE_IDLE : sfd_pkg::MODE_RESYNC;
                     end
                  end
                  default: begin
                     if (req_chan.data_byte == sfd_pkg::CODE_END) begin
                        mode_in = sfd_pkg::MODE_IDLE;
                     end
                  end
               endcase
               if (store) begin
                  if (base >= cap_eff) begin
                     ovf_in    = ovf_ff + 1'b1;
                     drop_in   = drop_ff + 1'b1;
                     len_in    = '0;
                     mode_in   = sfd_pkg::MODE_RESYNC;
                     status_in = sfd_pkg::ST_ERROR;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = base[sfd_pkg::ADDR_W-1:0];
                     len_in  = base + 1'b1;
                  end
               end
            end
            sfd_pkg::ACT_READ: begin
               rd_en    = 1'b1;
               rd_ok_in = (sfd_pkg::LEN_W'(req_chan.read_index) < len_ff);
            end
            sfd_pkg::ACT_RESTART: begin
               len_in  = '0;
               mode_in = sfd_pkg::MODE_IDLE;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sfd_pkg::MODE_IDLE;
         len_ff       <= '0;
         ok_ff        <= '0;
         ovf_ff       <= '0;
         bad_ff       <= '0;
         drop_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         ok_ff        <= ok_in;
         ovf_ff       <= ovf_in;
         bad_ff       <= bad_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
   end

   // frame buffer, one write or one read per transaction
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= store_val;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[req_chan.read_index[sfd_pkg::ADDR_W-1:0]];
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.frame_length     = len_ff;
   assign rsp_chan.read_data        = rd_ok_ff ? mem_q_ff : '0;
   assign rsp_chan.frames_ok_count  = ok_ff;
   assign rsp_chan.overflow_count   = ovf_ff;
   assign rsp_chan.bad_escape_count = bad_ff;
   assign rsp_chan.dropped_count    = drop_ff;

endmodule
